[design/assert_macros.svh]
// Assertion macros shared by the round robin line poller design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that an expression holds at every clock edge outside of reset.
`define RRLP_ASSERT(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Checks that a consequent holds in the same cycle as its antecedent.
`define RRLP_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Checks that a consequent holds in the cycle after its antecedent.
`define RRLP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/rrlp_pkg.sv]
// Package with types, constants and helpers of the round robin line poller.
package rrlp_pkg;

	localparam int DEVICE_COUNT = 4;
	localparam int TIMER_BITS = 16;
	localparam int DEV_W = (DEVICE_COUNT > 1) ? $clog2(DEVICE_COUNT) : 1;
	localparam int CFG_W = 16;
	localparam int CMP_W = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;
	localparam int CFG_IDX_W = 8;
	localparam int RES_DEPTH = 4;
	localparam int RES_PTR_W = $clog2(RES_DEPTH);
	localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

	localparam logic [DEV_W-1:0] DEV_LAST = DEV_W'(DEVICE_COUNT - 1);

	localparam logic [CFG_IDX_W-1:0] CFG_POLL_INTERVAL = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_RESPONSE_TIMEOUT = CFG_IDX_W'(1);
	localparam logic [CFG_W-1:0] POLL_INTERVAL_RESET = 16'd5000;
	localparam logic [CFG_W-1:0] RESPONSE_TIMEOUT_RESET = 16'd1000;

	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_VT = 8'h0B;
	localparam logic [7:0] CH_FF = 8'h0C;
	localparam logic [7:0] CH_BAR = 8'h7C;

	localparam logic [2:0] PREFIX_LEN = 3'd4;
	localparam logic [2:0] SEARCH_LEN = 3'd6;

	typedef enum logic [2:0] {
		EV_SEND = 3'd0,
		EV_TEMP = 3'd1,
		EV_UNKNOWN = 3'd2,
		EV_MISSED = 3'd3,
		EV_DONE = 3'd4
	} event_t;

	typedef enum logic [4:0] {
		PH_LEAD = 5'b00001,
		PH_PREFIX = 5'b00010,
		PH_SEARCH = 5'b00100,
		PH_FAIL = 5'b01000,
		PH_FOUND = 5'b10000
	} phase_t;

	typedef struct packed {
		phase_t ph;
		logic [2:0] ix;
	} match_t;

	typedef struct packed {
		event_t ev;
		logic [1:0] dev;
		logic last;
	} result_t;

	typedef struct packed {
		logic [1:0] n;
		result_t r0;
		result_t r1;
	} push_t;

	function automatic logic [7:0] prefix_char(input logic [2:0] ix);
		logic [7:0] c;
		unique case (ix)
			3'd0: c = 8'h43;
			3'd1: c = 8'h50;
			3'd2: c = 8'h55;
			3'd3: c = 8'h3A;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] search_char(input logic [2:0] ix);
		logic [7:0] c;
		unique case (ix)
			3'd0: c = 8'h7C;
			3'd1: c = 8'h4E;
			3'd2: c = 8'h56;
			3'd3: c = 8'h4D;
			3'd4: c = 8'h45;
			3'd5: c = 8'h3A;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	// The device port is two bits wide whatever the device count.
	function automatic logic [1:0] dev_field(input logic [DEV_W-1:0] dev);
		logic [31:0] w;
		w = 32'(dev);
		return w[1:0];
	endfunction

endpackage

[design/rrlp_line_match.sv]
// Next state of one device's line matcher for a received character.
module rrlp_line_match (
	input rrlp_pkg::match_t cur,
	input logic [7:0] rx_char,
	output rrlp_pkg::match_t nxt
);

	logic ws;
	logic [2:0] pix;
	logic [2:0] six;

	assign ws = (rx_char == rrlp_pkg::CH_SPACE) || (rx_char == rrlp_pkg::CH_TAB) ||
		(rx_char == rrlp_pkg::CH_VT) || (rx_char == rrlp_pkg::CH_FF);

	always_comb begin
		nxt = cur;
		pix = (cur.ph == rrlp_pkg::PH_LEAD) ? 3'd0 : cur.ix;
		six = 3'd0;
		unique case (cur.ph)
			rrlp_pkg::PH_LEAD, rrlp_pkg::PH_PREFIX: begin
				if ((cur.ph == rrlp_pkg::PH_LEAD) && ws) begin
					nxt = cur;
				end else if ((pix < rrlp_pkg::PREFIX_LEN) &&
					(rx_char == rrlp_pkg::prefix_char(pix))) begin
					if (pix == rrlp_pkg::PREFIX_LEN - 3'd1) begin
						nxt.ph = rrlp_pkg::PH_SEARCH;
						nxt.ix = 3'd0;
					end else begin
						nxt.ph = rrlp_pkg::PH_PREFIX;
						nxt.ix = pix + 3'd1;
					end
				end else begin
					nxt.ph = rrlp_pkg::PH_FAIL;
					nxt.ix = 3'd0;
				end
			end
			rrlp_pkg::PH_SEARCH: begin
				if ((cur.ix < rrlp_pkg::SEARCH_LEN) &&
					(rx_char == rrlp_pkg::search_char(cur.ix))) begin
					six = cur.ix + 3'd1;
				end else begin
					// A bar that breaks a partial match may start a new one.
					six = (rx_char == rrlp_pkg::CH_BAR) ? 3'd1 : 3'd0;
				end
				if (six == rrlp_pkg::SEARCH_LEN) begin
					nxt.ph = rrlp_pkg::PH_FOUND;
					nxt.ix = 3'd0;
				end else begin
					nxt.ph = rrlp_pkg::PH_SEARCH;
					nxt.ix = six;
				end
			end
			rrlp_pkg::PH_FOUND: begin
				nxt = cur;
			end
			default: begin
				nxt.ph = rrlp_pkg::PH_FAIL;
				nxt.ix = 3'd0;
			end
		endcase
	end

endmodule

[design/rrlp_result_fifo.sv]
// Result queue that takes up to two words a cycle and hands out one.
`include "assert_macros.svh"

module rrlp_result_fifo (
	input logic clk,
	input logic arst_n,
	input rrlp_pkg::push_t push,
	output logic room2,
	output logic out_valid,
	input logic out_ready,
	output rrlp_pkg::result_t out_word
);

	rrlp_pkg::result_t mem_q [rrlp_pkg::RES_DEPTH];
	logic [rrlp_pkg::RES_PTR_W-1:0] wr_q;
	logic [rrlp_pkg::RES_PTR_W-1:0] rd_q;
	logic [rrlp_pkg::RES_CNT_W-1:0] cnt_q;
	logic [rrlp_pkg::RES_PTR_W-1:0] wr1;
	logic pop;

	assign wr1 = wr_q + 1'b1;
	assign pop = out_valid && out_ready;
	assign out_valid = (cnt_q != '0);
	assign out_word = mem_q[rd_q];
	assign room2 = (cnt_q <= rrlp_pkg::RES_CNT_W'(rrlp_pkg::RES_DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			mem_q[wr_q] <= push.r0;
		end
		if (push.n == 2'd2) begin
			mem_q[wr1] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			wr_q <= wr_q + rrlp_pkg::RES_PTR_W'(push.n);
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			cnt_q <= cnt_q + rrlp_pkg::RES_CNT_W'(push.n) - rrlp_pkg::RES_CNT_W'(pop);
		end
	end

	`RRLP_ASSERT(a_fifo_no_overflow, cnt_q <= rrlp_pkg::RES_CNT_W'(rrlp_pkg::RES_DEPTH), "result queue overflow")
	`RRLP_ASSERT_IMPL(a_fifo_push_room, push.n != 2'd0, room2, "result pushed without room")

endmodule

[design/round_robin_line_poller_unit.sv]
// Top level of the round robin line poller: input stage, sweep control and result queue.
//
// Usage:
// The input channel (in_valid, in_ready, cmd, rx_byte) carries one word per item:
// a one millisecond tick when cmd is 0, or a byte received from the polled device
// when cmd is 1. The output channel (out_valid, out_ready, event_res, device, last)
// carries zero, one or two result words per item; last marks the final word of an
// item. The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) writes
// the poll interval (index 0) and the response timeout (index 1); it is always ready.
// An accepted item is held in the input register and processed there; its results are
// written into the result queue, from which the output channel hands them out. One
// item is taken every cycle while the four word result queue has room for two words;
// the output drains one word per cycle while out_ready is high, and this drain rate
// sets the sustained rate when items make results.
// Reset clears the sweep state, timers and all line matchers and loads the register
// defaults of 5000 ms and 1000 ms. When the receiver stalls, the result queue fills
// and in_ready drops once the held item can no longer be placed.
`include "assert_macros.svh"

module round_robin_line_poller_unit (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic cmd,
	input logic [7:0] rx_byte,
	output logic out_valid,
	input logic out_ready,
	output logic [2:0] event_res,
	output logic [1:0] device,
	output logic last,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [rrlp_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [rrlp_pkg::CFG_W-1:0] cfg_data
);

	logic valid_s1;
	logic cmd_s1;
	logic [7:0] byte_s1;

	logic [rrlp_pkg::CFG_W-1:0] interval_q;
	logic [rrlp_pkg::CFG_W-1:0] timeout_q;
	logic sweep_q;
	logic sent_q;
	logic [rrlp_pkg::DEV_W-1:0] dev_q;
	logic [rrlp_pkg::TIMER_BITS-1:0] since_q;
	logic [rrlp_pkg::TIMER_BITS-1:0] wait_q;
	rrlp_pkg::match_t match_q [rrlp_pkg::DEVICE_COUNT];

	logic sweep_n;
	logic sent_n;
	logic [rrlp_pkg::DEV_W-1:0] dev_n;
	logic [rrlp_pkg::TIMER_BITS-1:0] since_n;
	logic [rrlp_pkg::TIMER_BITS-1:0] wait_n;
	logic match_wr;
	rrlp_pkg::match_t match_wdata;

	rrlp_pkg::match_t match_cur;
	rrlp_pkg::match_t match_fed;
	rrlp_pkg::push_t push;
	rrlp_pkg::result_t out_word;
	logic room2;
	logic fire_s1;

	logic [rrlp_pkg::CFG_W-1:0] interval_eff;
	logic [rrlp_pkg::CFG_W-1:0] timeout_eff;

	assign cfg_ready = 1'b1;
	assign fire_s1 = valid_s1 && room2;
	assign in_ready = !valid_s1 || room2;
	assign interval_eff = (interval_q == '0) ? rrlp_pkg::CFG_W'(1) : interval_q;
	assign timeout_eff = (timeout_q == '0) ? rrlp_pkg::CFG_W'(1) : timeout_q;
	assign match_cur = match_q[dev_q];

	rrlp_line_match u_match (
		.cur(match_cur),
		.rx_char(byte_s1),
		.nxt(match_fed)
	);

	always_comb begin
		logic [rrlp_pkg::TIMER_BITS-1:0] since_inc;
		logic [rrlp_pkg::TIMER_BITS-1:0] wait_inc;
		logic start;
		logic do_adv;
		logic wrap;
		sweep_n = sweep_q;
		sent_n = sent_q;
		dev_n = dev_q;
		since_n = since_q;
		wait_n = wait_q;
		match_wr = 1'b0;
		match_wdata = match_fed;
		push.n = 2'd0;
		push.r0 = '{ev: rrlp_pkg::EV_SEND, dev: rrlp_pkg::dev_field(dev_q), last: 1'b0};
		push.r1 = '{ev: rrlp_pkg::EV_DONE, dev: rrlp_pkg::dev_field(rrlp_pkg::DEV_LAST),
			last: 1'b0};
		since_inc = (since_q == '1) ? since_q : since_q + 1'b1;
		wait_inc = (sent_q && (wait_q != '1)) ? wait_q + 1'b1 : wait_q;
		start = 1'b0;
		do_adv = 1'b0;
		wrap = (dev_q == rrlp_pkg::DEV_LAST);
		if (fire_s1) begin
			if (!cmd_s1) begin
				since_n = since_inc;
				wait_n = wait_inc;
				start = !sweep_q &&
					(rrlp_pkg::CMP_W'(since_inc) >= rrlp_pkg::CMP_W'(interval_eff));
				if (start) begin
					sweep_n = 1'b1;
					dev_n = '0;
					sent_n = 1'b0;
					wait_n = '0;
					since_n = '0;
				end
				if (sweep_q || start) begin
					if (start || !sent_q) begin
						push.n = 2'd1;
						push.r0.ev = rrlp_pkg::EV_SEND;
						push.r0.dev = start ? 2'd0 : rrlp_pkg::dev_field(dev_q);
						sent_n = 1'b1;
						wait_n = '0;
					end else if (rrlp_pkg::CMP_W'(wait_inc) >=
						rrlp_pkg::CMP_W'(timeout_eff)) begin
						// The matcher keeps its partial line across a missed poll.
						push.n = 2'd1;
						push.r0.ev = rrlp_pkg::EV_MISSED;
						do_adv = 1'b1;
					end
				end
			end else if (sweep_q && sent_q) begin
				if (byte_s1 == rrlp_pkg::CH_LF) begin
					push.n = 2'd1;
					push.r0.ev = (match_cur.ph == rrlp_pkg::PH_FOUND) ?
						rrlp_pkg::EV_TEMP : rrlp_pkg::EV_UNKNOWN;
					match_wr = 1'b1;
					match_wdata = '{ph: rrlp_pkg::PH_LEAD, ix: 3'd0};
					do_adv = 1'b1;
				end else if (byte_s1 != rrlp_pkg::CH_CR) begin
					match_wr = 1'b1;
				end
			end
		end
		if (do_adv) begin
			sent_n = 1'b0;
			wait_n = '0;
			if (wrap) begin
				sweep_n = 1'b0;
				dev_n = '0;
				push.n = 2'd2;
			end else begin
				dev_n = dev_q + 1'b1;
			end
		end
		if (push.n == 2'd2) begin
			push.r1.last = 1'b1;
		end else begin
			push.r0.last = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_s1 <= cmd;
			byte_s1 <= rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			interval_q <= rrlp_pkg::POLL_INTERVAL_RESET;
			timeout_q <= rrlp_pkg::RESPONSE_TIMEOUT_RESET;
			sweep_q <= 1'b0;
			sent_q <= 1'b0;
			dev_q <= '0;
			since_q <= '0;
			wait_q <= '0;
			for (int i = 0; i < rrlp_pkg::DEVICE_COUNT; i++) begin
				match_q[i] <= '{ph: rrlp_pkg::PH_LEAD, ix: 3'd0};
			end
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == rrlp_pkg::CFG_POLL_INTERVAL) begin
					interval_q <= cfg_data;
				end else if (cfg_index == rrlp_pkg::CFG_RESPONSE_TIMEOUT) begin
					timeout_q <= cfg_data;
				end
			end
			sweep_q <= sweep_n;
			sent_q <= sent_n;
			dev_q <= dev_n;
			since_q <= since_n;
			wait_q <= wait_n;
			if (match_wr) begin
				match_q[dev_q] <= match_wdata;
			end
		end
	end

	rrlp_result_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.room2(room2),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_word(out_word)
	);

	assign event_res = out_word.ev;
	assign device = out_word.dev;
	assign last = out_word.last;

	`RRLP_ASSERT_IMPL(a_sent_in_sweep, sent_q, sweep_q, "poll outstanding outside a sweep")
	`RRLP_ASSERT_IMPL(a_idle_at_first, !sweep_q, dev_q == '0, "idle block not at first device")
	`RRLP_ASSERT_NEXT(a_done_ends_sweep, (push.n == 2'd2) && (push.r1.ev == rrlp_pkg::EV_DONE), !sweep_q, "sweep still active after sweep done")

endmodule

[tb/sv/round_robin_line_poller_unit_test.sv]
// Self-checking testbench of the round robin line poller with a built-in sweep predictor.
`timescale 1ns / 1ps

module round_robin_line_poller_unit_test;
	import rrlp_pkg::*;

	localparam logic CMD_TICK = 1'b0;
	localparam logic CMD_BYTE = 1'b1;
	localparam int HALF_PERIOD = 5;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DIR_ROWS = 27;
	localparam logic [31:0] CPU_TAG = "CPU:";
	localparam logic [47:0] NVME_TAG = "|NVME:";
	localparam match_t MATCH_CLEAR = '{ph: PH_LEAD, ix: 3'd0};

	typedef struct packed {
		logic cmd;
		logic [7:0] data;
		bit fixed;
		logic [1:0] n;
		event_t ev_a;
		logic [1:0] dev_a;
		event_t ev_b;
		logic [1:0] dev_b;
	} probe_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic cmd = CMD_TICK;
	logic [7:0] rx_byte = 8'h00;
	logic out_valid;
	logic out_ready = 1'b1;
	logic [2:0] event_res;
	logic [1:0] device;
	logic last;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;

	// Sweep predictor state.
	logic [CFG_W-1:0] interval_reg = POLL_INTERVAL_RESET;
	logic [CFG_W-1:0] timeout_reg = RESPONSE_TIMEOUT_RESET;
	bit sweep_on = 1'b0;
	int dev_now = 0;
	bit poll_out = 1'b0;
	logic [TIMER_BITS-1:0] ms_since_sweep = '0;
	logic [TIMER_BITS-1:0] ms_waiting = '0;
	match_t line_state [DEVICE_COUNT] = '{default: MATCH_CLEAR};

	result_t due_results[$];
	int mismatches = 0;
	int cycles = 0;
	bit idle_on = 1'b1;
	int gap_pct = 20;
	int stall_pct = 20;
	int stall_left = 0;
	int r;

	logic [7:0] ws_set [4] = '{CH_SPACE, CH_TAB, CH_VT, CH_FF};

	probe_t dir_rows [0:DIR_ROWS-1] = '{
		'{CMD_BYTE, "C", 1'b1, 2'd0, EV_SEND, 2'd0, EV_SEND, 2'd0},
		'{CMD_TICK, 8'h00, 1'b0, 2'd0, EV_SEND, 2'd0, EV_SEND, 2'd0},
		'{CMD_TICK, 8'hFF, 1'b0, 2'd0, EV_SEND, 2'd0, EV_SEND, 2'd0},
		'{CMD_TICK, 8'h00, 1'b1, 2'd1, EV_SEND, 2'd0, EV_SEND, 2'd0},
		'{CMD_BYTE, CH_TAB, 1'b0, 2'd0, EV_SEND, 2'd0, EV_SEND, 2'd0},
		'{CMD_BYTE, "C", 1'b0, 2'd0, EV_SEND, 2'd0, EV_SEND, 2'd0},
		'{CMD_BYTE, "P", 1'b0, 2'd0, EV_SEND, 2'd0, EV_SEND, 2'd0},
		'{CMD_BYTE, "U", 1'b0, 2'd0, EV_SEND, 2'd0, EV_SEND, 2'd0},
		'{CMD_BYTE, ":", 1'b0, 2'd0, EV_SEND, 2'd0, EV_SEND, 2'd0},
		'{CMD_BYTE, CH_BAR, 1'b0, 2'd0, EV_SEND, 2'd0, EV_SEND, 2'd0},
		'{CMD_BYTE, CH_BAR, 1'b0, 2'd0, EV_SEND, 2'd0, EV_SEND, 2'd0},
		'{CMD_BYTE, "N", 1'b0, 2'd0, EV_SEND, 2'd0, EV_SEND, 2'd0},
		'{CMD_BYTE, "V", 1'b0, 2'd0, EV_SEND, 2'd0, EV_SEND, 2'd0},
		'{CMD_BYTE, "M", 1'b0, 2'd0, EV_SEND, 2'd0, EV_SEND, 2'd0},
		'{CMD_BYTE, "E", 1'b0, 2'd0, EV_SEND, 2'd0, EV_SEND, 2'd0},
		'{CMD_BYTE, ":", 1'b0, 2'd0, EV_SEND, 2'd0, EV_SEND, 2'd0},
		'{CMD_BYTE, CH_CR, 1'b0, 2'd0, EV_SEND, 2'd0, EV_SEND, 2'd0},
		'{CMD_BYTE, CH_LF, 1'b1, 2'd1, EV_TEMP, 2'd0, EV_SEND, 2'd0},
		'{CMD_BYTE, 8'hFF, 1'b1, 2'd0, EV_SEND, 2'd0, EV_SEND, 2'd0},
		'{CMD_TICK, 8'h00, 1'b0, 2'd0, EV_SEND, 2'd0, EV_SEND, 2'd0},
		'{CMD_TICK, 8'h00, 1'b0, 2'd0, EV_SEND, 2'd0, EV_SEND, 2'd0},
		'{CMD_TICK, 8'h00, 1'b1, 2'd1, EV_MISSED, 2'd1, EV_SEND, 2'd0},
		'{CMD_TICK, 8'h00, 1'b0, 2'd0, EV_SEND, 2'd0, EV_SEND, 2'd0},
		'{CMD_BYTE, 8'h00, 1'b0, 2'd0, EV_SEND, 2'd0, EV_SEND, 2'd0},
		'{CMD_BYTE, CH_LF, 1'b1, 2'd1, EV_UNKNOWN, 2'd2, EV_SEND, 2'd0},
		'{CMD_TICK, 8'h00, 1'b0, 2'd0, EV_SEND, 2'd0, EV_SEND, 2'd0},
		'{CMD_BYTE, CH_LF, 1'b1, 2'd2, EV_UNKNOWN, 2'd3, EV_DONE, 2'd3}
	};

	round_robin_line_poller_unit dut (.*);

	always #HALF_PERIOD clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	always @(negedge clk) begin
		if (!idle_on) begin
			out_ready <= 1'b1;
		end else if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left = stall_left - 1;
		end else if ($urandom_range(0, 99) < stall_pct) begin
			out_ready <= 1'b0;
			stall_left = $urandom_range(1, 5) - 1;
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (due_results.size() == 0) begin
				mismatches = mismatches + 1;
				if (mismatches <= 10)
					$display("unexpected result word: ev %0d dev %0d last %0d",
						event_res, device, last);
			end else begin
				want = due_results.pop_front();
				if (event_res !== want.ev || device !== want.dev || last !== want.last) begin
					mismatches = mismatches + 1;
					if (mismatches <= 10)
						$display(
							"mismatch: want ev %0d dev %0d last %0d, got ev %0d dev %0d last %0d",
							want.ev, want.dev, want.last, event_res, device, last);
				end
			end
		end
	end

	// Line classifier of one device: leading whitespace, the CPU tag, then a search for the
	// NVME tag that restarts on a bar.
	function automatic match_t match_feed(input match_t m, input logic [7:0] c);
		phase_t ph;
		int ix;
		ph = m.ph;
		ix = m.ix;
		if (ph == PH_LEAD) begin
			if (c == CH_SPACE || c == CH_TAB || c == CH_VT || c == CH_FF)
				return m;
			ph = PH_PREFIX;
			ix = 0;
		end
		if (ph == PH_PREFIX) begin
			if (ix < 4 && c == CPU_TAG[31-8*ix -: 8]) begin
				ix = ix + 1;
				if (ix == 4)
					return '{ph: PH_SEARCH, ix: 3'd0};
				return '{ph: PH_PREFIX, ix: 3'(ix)};
			end
			return '{ph: PH_FAIL, ix: 3'd0};
		end
		if (ph == PH_SEARCH) begin
			if (ix < 6 && c == NVME_TAG[47-8*ix -: 8])
				ix = ix + 1;
			else
				ix = (c == CH_BAR) ? 1 : 0;
			if (ix == 6)
				return '{ph: PH_FOUND, ix: 3'd0};
			return '{ph: PH_SEARCH, ix: 3'(ix)};
		end
		if (ph == PH_FOUND)
			return m;
		return '{ph: PH_FAIL, ix: 3'd0};
	endfunction

	// Advances the sweep model by one accepted word and queues the result words it causes.
	function automatic int poller_step(input logic c, input logic [7:0] b);
		result_t made[$];
		int intv;
		int tmo;
		bit next_dev;
		intv = (interval_reg == 0) ? 1 : interval_reg;
		tmo = (timeout_reg == 0) ? 1 : timeout_reg;
		next_dev = 1'b0;
		if (dev_now >= DEVICE_COUNT)
			dev_now = 0;
		if (c == CMD_TICK) begin
			if (ms_since_sweep != '1)
				ms_since_sweep = ms_since_sweep + 1'b1;
			if (poll_out && ms_waiting != '1)
				ms_waiting = ms_waiting + 1'b1;
			if (!sweep_on && ms_since_sweep >= intv) begin
				sweep_on = 1'b1;
				dev_now = 0;
				poll_out = 1'b0;
				ms_waiting = '0;
				ms_since_sweep = '0;
			end
			if (sweep_on) begin
				if (!poll_out) begin
					made.push_back('{ev: EV_SEND, dev: 2'(dev_now), last: 1'b0});
					poll_out = 1'b1;
					ms_waiting = '0;
				end else if (ms_waiting >= tmo) begin
					made.push_back('{ev: EV_MISSED, dev: 2'(dev_now), last: 1'b0});
					next_dev = 1'b1;
				end
			end
		end else if (sweep_on && poll_out) begin
			if (b == CH_LF) begin
				made.push_back('{ev: (line_state[dev_now].ph == PH_FOUND) ? EV_TEMP : EV_UNKNOWN,
					dev: 2'(dev_now), last: 1'b0});
				line_state[dev_now] = MATCH_CLEAR;
				next_dev = 1'b1;
			end else if (b != CH_CR) begin
				line_state[dev_now] = match_feed(line_state[dev_now], b);
			end
		end
		if (next_dev) begin
			poll_out = 1'b0;
			ms_waiting = '0;
			dev_now = dev_now + 1;
			if (dev_now >= DEVICE_COUNT) begin
				sweep_on = 1'b0;
				dev_now = 0;
				made.push_back('{ev: EV_DONE, dev: 2'(DEVICE_COUNT - 1), last: 1'b0});
			end
		end
		if (made.size() != 0)
			made[made.size()-1].last = 1'b1;
		foreach (made[i])
			due_results.push_back(made[i]);
		return made.size();
	endfunction

	// Entered and left at a falling edge. A word counts when the block acts on it.
	task automatic send_word(input logic c, input logic [7:0] b, output bit counted,
		output int made_n);
		if (idle_on && $urandom_range(0, 99) < gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
		end
		in_valid <= 1'b1;
		cmd <= c;
		rx_byte <= b;
		do @(posedge clk); while (!in_ready);
		counted = (c == CMD_TICK) || (sweep_on && poll_out);
		made_n = poller_step(c, b);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == CFG_POLL_INTERVAL)
			interval_reg = val;
		else if (idx == CFG_RESPONSE_TIMEOUT)
			timeout_reg = val;
		@(negedge clk);
	endtask

	// Waits until every result word has arrived and the pipeline has emptied, then writes.
	task automatic reconfigure(input logic [CFG_W-1:0] intv, input logic [CFG_W-1:0] tmo,
		input logic [CFG_IDX_W-1:0] stray_idx);
		in_valid <= 1'b0;
		while (due_results.size() != 0) @(negedge clk);
		repeat (6) @(negedge clk);
		write_reg(CFG_POLL_INTERVAL, intv);
		write_reg(CFG_RESPONSE_TIMEOUT, tmo);
		if (stray_idx > CFG_RESPONSE_TIMEOUT)
			write_reg(stray_idx, 16'($urandom));
		cfg_valid <= 1'b0;
	endtask

	task automatic run_phase(input int budget);
		int acted;
		int tmo_eff;
		int kind;
		int k;
		bit hit;
		int made_n;
		logic [7:0] line_bytes[$];
		acted = 0;
		tmo_eff = (timeout_reg == 0) ? 1 : timeout_reg;
		if (tmo_eff > 24)
			tmo_eff = 24;
		while (acted < budget) begin
			line_bytes.delete();
			if ($urandom_range(0, 99) < 40) begin
				repeat ($urandom_range(1, tmo_eff + 1)) begin
					send_word(CMD_TICK, 8'($urandom), hit, made_n);
					acted += hit;
				end
			end else begin
				kind = $urandom_range(0, 9);
				if (kind >= 8) begin
					repeat ($urandom_range(1, 6))
						line_bytes.push_back(8'($urandom));
					if ($urandom_range(0, 1))
						line_bytes.push_back(CH_LF);
				end else begin
					repeat ($urandom_range(0, 2))
						line_bytes.push_back(ws_set[$urandom_range(0, 3)]);
					for (k = 0; k < 4; k++)
						line_bytes.push_back(CPU_TAG[31-8*k -: 8]);
					repeat ($urandom_range(0, 3))
						line_bytes.push_back(8'($urandom_range(8'h20, 8'h7E)));
					for (k = 0; k < 6; k++)
						line_bytes.push_back(NVME_TAG[47-8*k -: 8]);
					repeat ($urandom_range(0, 3))
						line_bytes.push_back(8'($urandom_range(8'h20, 8'h7E)));
					if ($urandom_range(0, 2) == 0)
						line_bytes.push_back(CH_CR);
					// Broken lines: one byte replaced, or cut short so a timeout ends them.
					if (kind >= 6 && $urandom_range(0, 1)) begin
						line_bytes = line_bytes[0:$urandom_range(0, line_bytes.size() - 1)];
					end else begin
						if (kind >= 6) begin
							k = $urandom_range(0, line_bytes.size() - 1);
							line_bytes[k] = 8'($urandom_range(0, 255));
							if (line_bytes[k] == CH_LF)
								line_bytes[k] = 8'h00;
						end
						line_bytes.push_back(CH_LF);
					end
				end
				foreach (line_bytes[i]) begin
					if ($urandom_range(0, 9) == 0) begin
						send_word(CMD_TICK, 8'($urandom), hit, made_n);
						acted += hit;
					end
					send_word(CMD_BYTE, line_bytes[i], hit, made_n);
					acted += hit;
				end
			end
		end
	endtask

	task automatic pick_idling;
		gap_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
		stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
	endtask

	initial begin
		bit hit;
		int made_n;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		reconfigure(16'd3, 16'd2, '0);

		for (r = 0; r < DIR_ROWS; r++) begin
			send_word(dir_rows[r].cmd, dir_rows[r].data, hit, made_n);
			if (dir_rows[r].fixed) begin
				repeat (made_n) void'(due_results.pop_back());
				if (dir_rows[r].n >= 1)
					due_results.push_back('{ev: dir_rows[r].ev_a, dev: dir_rows[r].dev_a,
						last: (dir_rows[r].n == 1)});
				if (dir_rows[r].n == 2)
					due_results.push_back('{ev: dir_rows[r].ev_b, dev: dir_rows[r].dev_b,
						last: 1'b1});
			end
		end

		// A zero register value acts as one.
		reconfigure(16'd0, 16'd0, 8'hFF);
		pick_idling();
		run_phase(50);
		reconfigure(16'd1, 16'hFFFF, '0);
		pick_idling();
		run_phase(50);
		reconfigure(16'hFFFF, 16'd1, 8'($urandom_range(2, 254)));
		pick_idling();
		run_phase(30);
		repeat (4) begin
			reconfigure(16'($urandom_range(1, 12)), 16'($urandom_range(2, 20)), '0);
			pick_idling();
			run_phase(55);
		end
		reconfigure(16'($urandom_range(1, 12)), 16'($urandom_range(2, 20)), '0);
		idle_on = 1'b0;
		run_phase(50);

		in_valid <= 1'b0;
		while (due_results.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
